### src/cdda_pkg.sv
// ----------------------------------------------------------------------------
// cdda_pkg
// Shared types, constants, month table and microcode ROM for the
// calendar date day adder.
// ----------------------------------------------------------------------------
package cdda_pkg;

  // Field widths
  localparam int unsigned DAY_COUNT_BITS = 16;
  localparam int unsigned YEAR_W         = 14;
  localparam int unsigned MONTH_W        = 4;
  localparam int unsigned DAY_W          = 5;
  localparam int unsigned REQ_W          = 2;
  localparam int unsigned UPC_W          = 4;
  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned APB_DATA_W     = 32;

  // Calendar constants
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_MIN   = DAY_W'(1);
  localparam logic [DAY_W-1:0]   FEB_LEAP  = DAY_W'(29);
  localparam logic [DAY_W-1:0]   LONG_MONTH = DAY_W'(31);
  localparam logic [DAY_W-1:0]   CHUNK_DAYS = DAY_W'(28);
  localparam logic [DAY_COUNT_BITS-1:0] CHUNK_N = DAY_COUNT_BITS'(28);
  localparam logic [DAY_W-1:0]   MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Leap test: floor(y/25) = (y * 5243) >> 17 for y below 16384
  localparam int unsigned  RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(5243);
  localparam int unsigned  RECIP_SHIFT = 17;
  localparam int unsigned  PROD_W     = YEAR_W + RECIP_W;
  localparam int unsigned  QUOT_W     = PROD_W - RECIP_SHIFT;

  // Register indexes on the APB port
  localparam logic [1:0] REG_START_YEAR  = 2'd0;
  localparam logic [1:0] REG_START_MONTH = 2'd1;
  localparam logic [1:0] REG_START_DAY   = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_SUB  = 2'd1,
    REQ_LOAD = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  // Datapath operations driven by one control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_LEAP_MUL,
    OP_LEAP_CHK,
    OP_CHUNK,
    OP_COMMIT,
    OP_LOAD_MD,
    OP_EMIT
  } op_e;

  // Branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NOT_VALID,
    C_REQ_NONE,
    C_REQ_LOAD,
    C_CONT,
    C_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic             take;
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic req_none;
    logic req_load;
    logic cont;
    logic more;
    logic out_busy;
  } status_t;

  // Program addresses
  localparam logic [UPC_W-1:0] PC_FETCH    = UPC_W'(0);
  localparam logic [UPC_W-1:0] PC_DISPATCH = UPC_W'(1);
  localparam logic [UPC_W-1:0] PC_LEAP_MUL = UPC_W'(2);
  localparam logic [UPC_W-1:0] PC_LEAP_CHK = UPC_W'(3);
  localparam logic [UPC_W-1:0] PC_CHUNK    = UPC_W'(4);
  localparam logic [UPC_W-1:0] PC_RELOOP   = UPC_W'(5);
  localparam logic [UPC_W-1:0] PC_COMMIT   = UPC_W'(6);
  localparam logic [UPC_W-1:0] PC_LOAD_MD  = UPC_W'(7);
  localparam logic [UPC_W-1:0] PC_EMIT     = UPC_W'(15);

  // Days in month m (1..12) of a year with the given leap flag
  function automatic logic [DAY_W-1:0] days_in(input logic leap,
                                              input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] idx;
    idx = m - MONTH_JAN;
    if (m == MONTH_FEB && leap) begin
      days_in = FEB_LEAP;
    end else if (idx < MONTH_W'(12)) begin
      days_in = MONTH_LEN[idx];
    end else begin
      days_in = LONG_MONTH;
    end
  endfunction

  // Microcode ROM: a taken branch goes to target, else to the next word.
  // The last word falls through to the fetch word by wrap-around.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    w = '{take: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: PC_FETCH};
    unique case (upc)
      PC_FETCH:    w = '{take: 1'b1, op: OP_LATCH,    cond: C_NOT_VALID, target: PC_FETCH};
      PC_DISPATCH: w = '{take: 1'b0, op: OP_NOP,      cond: C_REQ_NONE,  target: PC_EMIT};
      PC_LEAP_MUL: w = '{take: 1'b0, op: OP_LEAP_MUL, cond: C_ALWAYS,    target: PC_LEAP_CHK};
      PC_LEAP_CHK: w = '{take: 1'b0, op: OP_LEAP_CHK, cond: C_REQ_LOAD,  target: PC_LOAD_MD};
      PC_CHUNK:    w = '{take: 1'b0, op: OP_CHUNK,    cond: C_CONT,      target: PC_CHUNK};
      PC_RELOOP:   w = '{take: 1'b0, op: OP_NOP,      cond: C_MORE,      target: PC_LEAP_MUL};
      PC_COMMIT:   w = '{take: 1'b0, op: OP_COMMIT,   cond: C_ALWAYS,    target: PC_EMIT};
      PC_LOAD_MD:  w = '{take: 1'b0, op: OP_LOAD_MD,  cond: C_ALWAYS,    target: PC_EMIT};
      PC_EMIT:     w = '{take: 1'b0, op: OP_EMIT,     cond: C_OUT_BUSY,  target: PC_EMIT};
      default:     w = '{take: 1'b0, op: OP_NOP,      cond: C_ALWAYS,    target: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

### src/calendar_date_day_adder.sv
// ----------------------------------------------------------------------------
// calendar_date_day_adder
// Gregorian date register that moves forward or backward by a day count.
// ----------------------------------------------------------------------------
// One request is handled at a time. An add or subtract of n days walks
// K = max(1, ceil(n/28)) chunks of at most 28 days in the chunk step of
// the microcode program (one chunk per cycle); each year boundary crossed
// before the walk ends costs a leap-year recompute (multiply step, then
// check step) plus one branch step. A new request may be taken while the
// previous result still waits.
// ----------------------------------------------------------------------------
module calendar_date_day_adder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Request channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cdda_pkg::REQ_W-1:0]            req_type_i,
  input  logic [15:0]                           day_count_i,
  // Result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [cdda_pkg::YEAR_W-1:0]           year_o,
  output logic [cdda_pkg::MONTH_W-1:0]          month_o,
  output logic [cdda_pkg::DAY_W-1:0]            day_o,
  output logic                                  range_error_o,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cdda_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [cdda_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [cdda_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  logic [cdda_pkg::YEAR_W-1:0]  start_year_q;
  logic [cdda_pkg::MONTH_W-1:0] start_month_q;
  logic [cdda_pkg::DAY_W-1:0]   start_day_q;
  logic [1:0]                   reg_idx;
  logic                         wr_en;

  cdda_pkg::ucode_t  ctrl;
  cdda_pkg::status_t status;

  // Register file: write on the access phase of a transfer
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_year_q  <= cdda_pkg::YEAR_W'(2000);
      start_month_q <= cdda_pkg::MONTH_JAN;
      start_day_q   <= cdda_pkg::DAY_MIN;
    end else if (wr_en) begin
      case (reg_idx)
        cdda_pkg::REG_START_YEAR:  start_year_q  <= pwdata[cdda_pkg::YEAR_W-1:0];
        cdda_pkg::REG_START_MONTH: start_month_q <= pwdata[cdda_pkg::MONTH_W-1:0];
        cdda_pkg::REG_START_DAY:   start_day_q   <= pwdata[cdda_pkg::DAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      cdda_pkg::REG_START_YEAR:  prdata = cdda_pkg::APB_DATA_W'(start_year_q);
      cdda_pkg::REG_START_MONTH: prdata = cdda_pkg::APB_DATA_W'(start_month_q);
      cdda_pkg::REG_START_DAY:   prdata = cdda_pkg::APB_DATA_W'(start_day_q);
      default:                   prdata = '0;
    endcase
  end

  // Take requests only at the fetch step
  assign in_stall_o = ~ctrl.take;

  cdda_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  cdda_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .in_valid_i    (in_valid_i),
    .req_type_i    (req_type_i),
    .day_count_i   (day_count_i[cdda_pkg::DAY_COUNT_BITS-1:0]),
    .start_year_i  (start_year_q),
    .start_month_i (start_month_q),
    .start_day_i   (start_day_q),
    .out_stall_i   (out_stall_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .year_o        (year_o),
    .month_o       (month_o),
    .day_o         (day_o),
    .range_error_o (range_error_o)
  );

endmodule

### src/cdda_seq.sv
// ----------------------------------------------------------------------------
// cdda_seq
// Microcode sequencer: step counter, control word ROM and branch logic.
// ----------------------------------------------------------------------------
module cdda_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdda_pkg::status_t status_i,
  output cdda_pkg::ucode_t  ctrl_o
);

  logic [cdda_pkg::UPC_W-1:0] upc_q, upc_d;
  cdda_pkg::ucode_t           word;
  logic                       taken;

  // Look up the control word of this step
  assign word   = cdda_pkg::ucode_rom(upc_q);
  assign ctrl_o = word;

  // Evaluate the branch condition
  always_comb begin
    unique case (word.cond)
      cdda_pkg::C_ALWAYS:    taken = 1'b1;
      cdda_pkg::C_NOT_VALID: taken = ~status_i.in_valid;
      cdda_pkg::C_REQ_NONE:  taken = status_i.req_none;
      cdda_pkg::C_REQ_LOAD:  taken = status_i.req_load;
      cdda_pkg::C_CONT:      taken = status_i.cont;
      cdda_pkg::C_MORE:      taken = status_i.more;
      cdda_pkg::C_OUT_BUSY:  taken = status_i.out_busy;
      default:               taken = 1'b1;
    endcase
  end

  // Jump or advance; the last word wraps to fetch
  assign upc_d = taken ? word.target : upc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= cdda_pkg::PC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

### src/cdda_dp.sv
// ----------------------------------------------------------------------------
// cdda_dp
// Date datapath: stored date, working date, leap unit, chunk step and the
// result register.
// ----------------------------------------------------------------------------
module cdda_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cdda_pkg::ucode_t                    ctrl_i,
  input  logic                                in_valid_i,
  input  logic [cdda_pkg::REQ_W-1:0]          req_type_i,
  input  logic [cdda_pkg::DAY_COUNT_BITS-1:0] day_count_i,
  input  logic [cdda_pkg::YEAR_W-1:0]         start_year_i,
  input  logic [cdda_pkg::MONTH_W-1:0]        start_month_i,
  input  logic [cdda_pkg::DAY_W-1:0]          start_day_i,
  input  logic                                out_stall_i,
  output cdda_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  output logic [cdda_pkg::YEAR_W-1:0]         year_o,
  output logic [cdda_pkg::MONTH_W-1:0]        month_o,
  output logic [cdda_pkg::DAY_W-1:0]          day_o,
  output logic                                range_error_o
);

  localparam int unsigned YW = cdda_pkg::YEAR_W;
  localparam int unsigned MW = cdda_pkg::MONTH_W;
  localparam int unsigned DW = cdda_pkg::DAY_W;
  localparam int unsigned NW = cdda_pkg::DAY_COUNT_BITS;

  // Stored date and flags
  logic [YW-1:0] cur_year_q, cur_year_d;
  logic [MW-1:0] cur_month_q, cur_month_d;
  logic [DW-1:0] cur_day_q, cur_day_d;
  logic          err_q, err_d;
  logic          more_q, more_d;
  logic          out_valid_q, out_valid_d;

  // Working registers
  cdda_pkg::req_e               req_q;
  logic [NW-1:0]                n_q;
  logic [YW-1:0]                y_q;
  logic [MW-1:0]                m_q;
  logic [DW-1:0]                d_q;
  logic                         leap_q;
  logic [cdda_pkg::PROD_W-1:0]  prod_q;
  logic [YW-1:0]                year_q;
  logic [MW-1:0]                month_q;
  logic [DW-1:0]                day_q;
  logic                         rerr_q;

  cdda_pkg::op_e op;
  logic          latch_go;
  logic          emit_go;
  logic          out_busy;

  // Chunk step signals
  logic          n_big;
  logic [DW-1:0] c;
  logic [DW-1:0] dim;
  logic [DW-1:0] dim_prev;
  logic [MW-1:0] m_prev;
  logic [DW:0]   sum6;
  logic [YW-1:0] ny;
  logic [MW-1:0] nm;
  logic [DW-1:0] nd;
  logic          nerr;
  logic          ychg;

  // Leap and load signals
  logic [YW-1:0]                sy_clamp;
  logic [cdda_pkg::QUOT_W-1:0]  quot;
  logic [YW-1:0]                q25;
  logic [YW-1:0]                rem25;
  logic                         leap_new;
  logic [MW-1:0]                lm;
  logic [DW-1:0]                lim;
  logic [DW-1:0]                ld;

  assign op       = ctrl_i.op;
  assign latch_go = (op == cdda_pkg::OP_LATCH) && in_valid_i;
  assign out_busy = out_valid_q & out_stall_i;
  assign emit_go  = (op == cdda_pkg::OP_EMIT) && !out_busy;

  // Clamp the start year into 1..9999
  always_comb begin
    if (start_year_i < cdda_pkg::YEAR_MIN) begin
      sy_clamp = cdda_pkg::YEAR_MIN;
    end else if (start_year_i > cdda_pkg::YEAR_MAX) begin
      sy_clamp = cdda_pkg::YEAR_MAX;
    end else begin
      sy_clamp = start_year_i;
    end
  end

  // Leap check from the registered reciprocal product
  always_comb begin
    quot     = prod_q[cdda_pkg::PROD_W-1:cdda_pkg::RECIP_SHIFT];
    q25      = YW'({quot, 4'b0}) + YW'({quot, 3'b0}) + YW'(quot);
    rem25    = y_q - q25;
    leap_new = (y_q[1:0] == 2'b00) && ((rem25 != '0) || (y_q[3:0] == 4'b0000));
  end

  // Clamp start month and day against the month length
  always_comb begin
    if (start_month_i < cdda_pkg::MONTH_JAN) begin
      lm = cdda_pkg::MONTH_JAN;
    end else if (start_month_i > cdda_pkg::MONTH_DEC) begin
      lm = cdda_pkg::MONTH_DEC;
    end else begin
      lm = start_month_i;
    end
    lim = cdda_pkg::days_in(leap_q, lm);
    if (start_day_i < cdda_pkg::DAY_MIN) begin
      ld = cdda_pkg::DAY_MIN;
    end else if (start_day_i > lim) begin
      ld = lim;
    end else begin
      ld = start_day_i;
    end
  end

  // One chunk of at most 28 days, carrying or borrowing at most one month
  always_comb begin
    n_big    = n_q > cdda_pkg::CHUNK_N;
    c        = n_big ? cdda_pkg::CHUNK_DAYS : n_q[DW-1:0];
    dim      = cdda_pkg::days_in(leap_q, m_q);
    m_prev   = (m_q == cdda_pkg::MONTH_JAN) ? cdda_pkg::MONTH_DEC : m_q - 1'b1;
    dim_prev = cdda_pkg::days_in(leap_q, m_prev);
    sum6     = {1'b0, d_q} + {1'b0, c};
    ny       = y_q;
    nm       = m_q;
    nd       = d_q;
    nerr     = 1'b0;
    ychg     = 1'b0;
    if (req_q == cdda_pkg::REQ_ADD) begin
      if (sum6 > {1'b0, dim}) begin
        nd = DW'(sum6 - {1'b0, dim});
        if (m_q == cdda_pkg::MONTH_DEC) begin
          nm   = cdda_pkg::MONTH_JAN;
          ychg = 1'b1;
          nerr = (y_q == cdda_pkg::YEAR_MAX);
          ny   = nerr ? y_q : y_q + 1'b1;
        end else begin
          nm = m_q + 1'b1;
        end
      end else begin
        nd = sum6[DW-1:0];
      end
    end else begin
      if (d_q > c) begin
        nd = d_q - c;
      end else begin
        nm = m_prev;
        nd = DW'({1'b0, dim_prev} + {1'b0, d_q} - {1'b0, c});
        if (m_q == cdda_pkg::MONTH_JAN) begin
          ychg = 1'b1;
          nerr = (y_q <= cdda_pkg::YEAR_MIN);
          ny   = nerr ? y_q : y_q - 1'b1;
        end
      end
    end
  end

  // Status for the sequencer
  always_comb begin
    status_o.in_valid = in_valid_i;
    status_o.req_none = (req_q == cdda_pkg::REQ_NONE);
    status_o.req_load = (req_q == cdda_pkg::REQ_LOAD);
    status_o.cont     = n_big && !nerr && !ychg;
    status_o.more     = more_q;
    status_o.out_busy = out_busy;
  end

  // Next values of the stored date and flags
  always_comb begin
    cur_year_d  = cur_year_q;
    cur_month_d = cur_month_q;
    cur_day_d   = cur_day_q;
    err_d       = err_q;
    more_d      = more_q;
    if (latch_go) begin
      err_d = 1'b0;
    end
    if (op == cdda_pkg::OP_CHUNK) begin
      err_d  = nerr;
      more_d = n_big && !nerr;
    end
    if (op == cdda_pkg::OP_COMMIT && !err_q) begin
      cur_year_d  = y_q;
      cur_month_d = m_q;
      cur_day_d   = d_q;
    end
    if (op == cdda_pkg::OP_LOAD_MD) begin
      cur_year_d  = y_q;
      cur_month_d = lm;
      cur_day_d   = ld;
    end
    out_valid_d = emit_go | out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= YW'(2000);
      cur_month_q <= cdda_pkg::MONTH_JAN;
      cur_day_q   <= cdda_pkg::DAY_MIN;
      err_q       <= 1'b0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_year_q  <= cur_year_d;
      cur_month_q <= cur_month_d;
      cur_day_q   <= cur_day_d;
      err_q       <= err_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    if (latch_go) begin
      req_q <= cdda_pkg::req_e'(req_type_i);
      n_q   <= day_count_i;
      y_q   <= (cdda_pkg::req_e'(req_type_i) == cdda_pkg::REQ_LOAD) ? sy_clamp : cur_year_q;
      m_q   <= cur_month_q;
      d_q   <= cur_day_q;
    end
    if (op == cdda_pkg::OP_LEAP_MUL) begin
      prod_q <= y_q * cdda_pkg::RECIP_25;
    end
    if (op == cdda_pkg::OP_LEAP_CHK) begin
      leap_q <= leap_new;
    end
    if (op == cdda_pkg::OP_CHUNK) begin
      y_q <= ny;
      m_q <= nm;
      d_q <= nd;
      if (n_big) begin
        n_q <= n_q - cdda_pkg::CHUNK_N;
      end
    end
    if (emit_go) begin
      year_q  <= cur_year_q;
      month_q <= cur_month_q;
      day_q   <= cur_day_q;
      rerr_q  <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign year_o        = year_q;
  assign month_o       = month_q;
  assign day_o         = day_q;
  assign range_error_o = rerr_q;

`ifndef SYNTHESIS
  a_cur_date_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_month_q >= cdda_pkg::MONTH_JAN) && (cur_month_q <= cdda_pkg::MONTH_DEC) &&
    (cur_day_q != '0))
    else $error("stored date holds an invalid month or day");

  a_chunk_date_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == cdda_pkg::OP_CHUNK) |->
      (m_q >= cdda_pkg::MONTH_JAN) && (m_q <= cdda_pkg::MONTH_DEC) &&
      (d_q != '0) && (d_q <= cdda_pkg::days_in(leap_q, m_q)))
    else $error("working date invalid at a chunk step");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(op == cdda_pkg::OP_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule
